### rtl/core/wrap_aware_timer_queue_macros.svh
// Assertion macros for the wrap-aware timer queue checker.
`ifndef WRAP_AWARE_TIMER_QUEUE_MACROS_SVH
`define WRAP_AWARE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WTQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtq check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtq check failed");

`endif

### rtl/core/wtq_pkg.sv
// Shared types, constants and helpers of the wrap-aware timer queue.
package wtq_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 32;
  localparam int HEAD_W     = 5;
  localparam int INTERVAL_W = 31;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 31'd7200000;
  localparam logic [TIME_W-1:0]     SIGN_BIT       = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_DELETE,
    CMD_DISPATCH,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_CLOSE,
    ST_QUEUED
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_HEAD,
    S_WALK,
    S_LINK_E,
    S_LINK_P,
    S_DEL_HEAD,
    S_DEL_WALK,
    S_DEL_FIX,
    S_DSP_NEXT,
    S_DSP_CMP,
    S_FIN_RD,
    S_FIN
  } state_t;

  // a is before b modulo 2^32
  function automatic logic is_before(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d & SIGN_BIT) != '0;
  endfunction

endpackage

### rtl/core/wtq_if.sv
// Request, result and configuration channel interfaces of the timer queue.
interface wtq_in_if;
  logic                         valid;
  logic                         ready;
  wtq_pkg::cmd_t                command;
  logic [wtq_pkg::SLOT_W-1:0]   slot;
  logic [wtq_pkg::TIME_W-1:0]   waketime;
  logic [wtq_pkg::TIME_W-1:0]   now;
  logic                         callback_done;

  modport source (output valid, command, slot, waketime, now, callback_done,
                  input ready);
  modport sink (input valid, command, slot, waketime, now, callback_done,
                output ready);
endinterface

interface wtq_out_if;
  logic                         valid;
  logic                         ready;
  wtq_pkg::status_t             status;
  logic [wtq_pkg::HEAD_W-1:0]   head_slot;
  logic [wtq_pkg::TIME_W-1:0]   head_wake;
  logic                         wake_tasks;

  modport source (output valid, status, head_slot, head_wake, wake_tasks,
                  input ready);
  modport sink (input valid, status, head_slot, head_wake, wake_tasks,
                output ready);
endinterface

interface wtq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wtq_pkg::INTERVAL_W-1:0]   periodic_interval;

  modport source (output valid, periodic_interval, input ready);
  modport sink (input valid, periodic_interval, output ready);
endinterface

### rtl/core/wrap_aware_timer_queue.sv
// Wrap-aware sorted timer queue: linked list of timer slots in memory.
// One request is taken at a time and gives one result. The list lives in two
// memories (wake time, next pointer), each with one read and one write port
// and a registered read, and the insert and delete walks read one list entry
// per cycle. A request finishes only once the previous result has been taken
// on out_ch.ready. The periodic entry's wake time and next pointer sit in
// registers. No clearing pass is needed after reset.
module wrap_aware_timer_queue (
  input  logic       clk,
  input  logic       rst_n,
  wtq_in_if.sink     in_ch,
  wtq_out_if.source  out_ch,
  wtq_cfg_if.sink    cfg_ch
);

  localparam int NUM_SLOTS = wtq_pkg::NUM_SLOTS;
  localparam int EW = $clog2(NUM_SLOTS + 2);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [EW-1:0] PER  = EW'(NUM_SLOTS);
  localparam logic [EW-1:0] ENDM = EW'(NUM_SLOTS + 1);

  wtq_pkg::state_t state_r, state_nxt;

  logic [EW-1:0]                     head_r, head_nxt;
  logic [EW-1:0]                     per_next_r, per_next_nxt;
  logic [wtq_pkg::TIME_W-1:0]        per_wake_r, per_wake_nxt;
  logic [NUM_SLOTS-1:0]              queued_r, queued_nxt;
  logic [wtq_pkg::INTERVAL_W-1:0]    interval_r;

  logic [EW-1:0]                     e_r, e_nxt;
  logic [EW-1:0]                     prev_r, prev_nxt;
  logic [EW-1:0]                     cur_r, cur_nxt;
  logic [wtq_pkg::TIME_W-1:0]        w_r, w_nxt;
  logic [wtq_pkg::TIME_W-1:0]        now_r, now_nxt;
  wtq_pkg::status_t                  status_r, status_nxt;
  logic                              wt_r, wt_nxt;

  logic                              out_valid_r;
  wtq_pkg::status_t                  out_status_r;
  logic [wtq_pkg::HEAD_W-1:0]        out_head_r;
  logic [wtq_pkg::TIME_W-1:0]        out_wake_r;
  logic                              out_wt_r;
  logic                              out_load;

  logic [wtq_pkg::TIME_W-1:0]        wake_mem [NUM_SLOTS];
  logic [EW-1:0]                     next_mem [NUM_SLOTS];
  logic [wtq_pkg::TIME_W-1:0]        wake_q;
  logic [EW-1:0]                     next_q;
  logic [EW-1:0]                     ridx_r;
  logic [EW-1:0]                     rd_addr;
  logic                              wake_we;
  logic [EW-1:0]                     wake_wa;
  logic [wtq_pkg::TIME_W-1:0]        wake_wd;
  logic                              next_we;
  logic [EW-1:0]                     next_wa;
  logic [EW-1:0]                     next_wd;

  logic [wtq_pkg::TIME_W-1:0]        rd_wake;
  logic [EW-1:0]                     rd_next;
  logic [EW-1:0]                     s_idx;
  logic                              slot_ok;
  logic                              walk_go;
  logic [EW-1:0]                     walk_p;
  logic [EW-1:0]                     walk_n;

  assign rd_wake = (ridx_r == PER) ? per_wake_r : wake_q;
  assign rd_next = (ridx_r == PER) ? per_next_r : next_q;
  assign s_idx   = EW'(in_ch.slot);
  assign slot_ok = int'(in_ch.slot) < NUM_SLOTS;

  assign in_ch.ready  = (state_r == wtq_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.head_slot  = out_head_r;
  assign out_ch.head_wake  = out_wake_r;
  assign out_ch.wake_tasks = out_wt_r;

  always_ff @(posedge clk) begin
    if (wake_we) begin
      wake_mem[wake_wa[SW-1:0]] <= wake_wd;
    end
    if (next_we && (next_wa != PER)) begin
      next_mem[next_wa[SW-1:0]] <= next_wd;
    end
    wake_q <= wake_mem[rd_addr[SW-1:0]];
    next_q <= next_mem[rd_addr[SW-1:0]];
    ridx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wtq_pkg::S_IDLE;
      head_r      <= PER;
      per_next_r  <= ENDM;
      per_wake_r  <= '0;
      queued_r    <= '0;
      interval_r  <= wtq_pkg::INTERVAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      per_next_r <= per_next_nxt;
      per_wake_r <= per_wake_nxt;
      queued_r   <= queued_nxt;
      if (cfg_ch.valid) begin
        interval_r <= cfg_ch.periodic_interval;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    prev_r   <= prev_nxt;
    cur_r    <= cur_nxt;
    w_r      <= w_nxt;
    now_r    <= now_nxt;
    status_r <= status_nxt;
    wt_r     <= wt_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_head_r   <= wtq_pkg::HEAD_W'(head_r);
      out_wake_r   <= rd_wake;
      out_wt_r     <= wt_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    per_next_nxt = per_next_r;
    per_wake_nxt = per_wake_r;
    queued_nxt   = queued_r;
    e_nxt        = e_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    w_nxt        = w_r;
    now_nxt      = now_r;
    status_nxt   = status_r;
    wt_nxt       = wt_r;
    rd_addr      = head_r;
    wake_we      = 1'b0;
    wake_wa      = e_r;
    wake_wd      = w_r;
    next_we      = 1'b0;
    next_wa      = e_r;
    next_wd      = head_r;
    out_load     = 1'b0;
    walk_go      = 1'b0;
    walk_p       = cur_r;
    walk_n       = rd_next;

    case (state_r)
      wtq_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          e_nxt      = s_idx;
          w_nxt      = in_ch.waketime;
          now_nxt    = in_ch.now;
          status_nxt = wtq_pkg::ST_OK;
          wt_nxt     = 1'b0;
          state_nxt  = wtq_pkg::S_FIN_RD;
          case (in_ch.command)
            wtq_pkg::CMD_ADD: begin
              if (slot_ok) begin
                if (queued_r[s_idx[SW-1:0]]) begin
                  status_nxt = wtq_pkg::ST_QUEUED;
                end else begin
                  rd_addr   = head_r;
                  state_nxt = wtq_pkg::S_ADD_HEAD;
                end
              end
            end
            wtq_pkg::CMD_DELETE: begin
              if (slot_ok && queued_r[s_idx[SW-1:0]]) begin
                queued_nxt[s_idx[SW-1:0]] = 1'b0;
                if (head_r == s_idx) begin
                  rd_addr   = s_idx;
                  state_nxt = wtq_pkg::S_DEL_HEAD;
                end else begin
                  rd_addr   = head_r;
                  cur_nxt   = head_r;
                  state_nxt = wtq_pkg::S_DEL_WALK;
                end
              end
            end
            wtq_pkg::CMD_DISPATCH: begin
              e_nxt = head_r;
              if (head_r == PER) begin
                per_wake_nxt = per_wake_r + {1'b0, interval_r};
                w_nxt        = per_wake_nxt;
                wt_nxt       = 1'b1;
                if (per_next_r <= PER) begin
                  rd_addr   = per_next_r;
                  cur_nxt   = per_next_r;
                  state_nxt = wtq_pkg::S_DSP_CMP;
                end
              end else if (in_ch.callback_done) begin
                queued_nxt[head_r[SW-1:0]] = 1'b0;
                rd_addr   = head_r;
                state_nxt = wtq_pkg::S_DEL_HEAD;
              end else begin
                wake_we   = 1'b1;
                wake_wa   = head_r;
                wake_wd   = in_ch.waketime;
                rd_addr   = head_r;
                state_nxt = wtq_pkg::S_DSP_NEXT;
              end
            end
            default: begin
              queued_nxt   = '0;
              per_next_nxt = ENDM;
              head_nxt     = PER;
            end
          endcase
        end
      end

      wtq_pkg::S_ADD_HEAD: begin
        state_nxt = wtq_pkg::S_FIN_RD;
        if (wtq_pkg::is_before(w_r, rd_wake)) begin
          if (wtq_pkg::is_before(w_r, now_r)) begin
            status_nxt = wtq_pkg::ST_TOO_CLOSE;
          end else begin
            wake_we                 = 1'b1;
            next_we                 = 1'b1;
            next_wa                 = e_r;
            next_wd                 = head_r;
            head_nxt                = e_r;
            queued_nxt[e_r[SW-1:0]] = 1'b1;
          end
        end else begin
          wake_we                 = 1'b1;
          queued_nxt[e_r[SW-1:0]] = 1'b1;
          walk_go                 = 1'b1;
          walk_p                  = head_r;
        end
      end

      wtq_pkg::S_WALK: begin
        if (wtq_pkg::is_before(w_r, rd_wake)) begin
          state_nxt = wtq_pkg::S_LINK_E;
        end else begin
          walk_go = 1'b1;
          walk_p  = cur_r;
        end
      end

      wtq_pkg::S_LINK_E: begin
        next_we   = 1'b1;
        next_wa   = e_r;
        next_wd   = cur_r;
        state_nxt = wtq_pkg::S_LINK_P;
      end

      wtq_pkg::S_LINK_P: begin
        next_we   = 1'b1;
        next_wa   = prev_r;
        next_wd   = e_r;
        state_nxt = wtq_pkg::S_FIN_RD;
      end

      wtq_pkg::S_DEL_HEAD: begin
        head_nxt  = (rd_next <= PER) ? rd_next : PER;
        state_nxt = wtq_pkg::S_FIN_RD;
      end

      wtq_pkg::S_DEL_WALK: begin
        if (rd_next > PER) begin
          state_nxt = wtq_pkg::S_FIN_RD;
        end else if (rd_next == e_r) begin
          prev_nxt  = cur_r;
          rd_addr   = e_r;
          state_nxt = wtq_pkg::S_DEL_FIX;
        end else begin
          cur_nxt = rd_next;
          rd_addr = rd_next;
        end
      end

      wtq_pkg::S_DEL_FIX: begin
        next_we   = 1'b1;
        next_wa   = prev_r;
        next_wd   = rd_next;
        state_nxt = wtq_pkg::S_FIN_RD;
      end

      wtq_pkg::S_DSP_NEXT: begin
        if (rd_next > PER) begin
          state_nxt = wtq_pkg::S_FIN_RD;
        end else begin
          rd_addr   = rd_next;
          cur_nxt   = rd_next;
          state_nxt = wtq_pkg::S_DSP_CMP;
        end
      end

      wtq_pkg::S_DSP_CMP: begin
        if (!wtq_pkg::is_before(w_r, rd_wake)) begin
          head_nxt = cur_r;
          walk_go  = 1'b1;
          walk_p   = cur_r;
        end else begin
          state_nxt = wtq_pkg::S_FIN_RD;
        end
      end

      wtq_pkg::S_FIN_RD: begin
        rd_addr   = head_r;
        state_nxt = wtq_pkg::S_FIN;
      end

      wtq_pkg::S_FIN: begin
        rd_addr = head_r;
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = wtq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wtq_pkg::S_IDLE;
      end
    endcase

    // one insert step: prev is walk_p, its successor is walk_n
    if (walk_go) begin
      prev_nxt = walk_p;
      if (walk_n > PER) begin
        cur_nxt   = ENDM;
        state_nxt = wtq_pkg::S_LINK_E;
      end else begin
        cur_nxt   = walk_n;
        rd_addr   = walk_n;
        state_nxt = wtq_pkg::S_WALK;
      end
    end

    if (next_we && (next_wa == PER)) begin
      per_next_nxt = next_wd;
    end
  end

endmodule

### rtl/core/wtq_checker.sv
// Port-level checks of the wrap-aware timer queue, bound to the top level.
`include "wrap_aware_timer_queue_macros.svh"

module wtq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [wtq_pkg::HEAD_W-1:0]    head_slot,
  input logic [wtq_pkg::TIME_W-1:0]    head_wake,
  input logic                          wake_tasks
);

  `WTQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({head_slot, head_wake}))
  `WTQ_ASSERT_IMPL(a_head_range, out_valid, int'(head_slot) <= wtq_pkg::NUM_SLOTS)
  `WTQ_ASSERT_IMPL(a_fire_ok, out_valid && wake_tasks, status == wtq_pkg::ST_OK)
  `WTQ_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

endmodule

bind wrap_aware_timer_queue wtq_checker u_wtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .head_slot  (out_ch.head_slot),
  .head_wake  (out_ch.head_wake),
  .wake_tasks (out_ch.wake_tasks)
);
